/* sv/scanline_repeat_tone_generator_macros.svh */
// assertion macros for the scan-out sequencer
`ifndef SCANLINE_REPEAT_TONE_GENERATOR_MACROS_SVH
`define SCANLINE_REPEAT_TONE_GENERATOR_MACROS_SVH

// same-cycle implication
`define SRTG_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srtg assertion failed");

// next-cycle implication
`define SRTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srtg assertion failed");

`endif

/* sv/srtg_pkg.sv */
`default_nettype none
package srtg_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ADDR_W    = 11;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned ROW_W     = 7;
  localparam int unsigned REP_W     = 3;
  localparam int unsigned REPCFG_W  = 4;
  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_HSYNC = 2'd0,
    CMD_VSYNC = 2'd1,
    CMD_STORE = 2'd2
  } cmd_e;

  localparam logic [REG_IDX_W-1:0] REG_TONE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SKIP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT = 2'd2;

  localparam logic [BYTE_W-1:0]   SKIP_RESET   = 8'd90;
  localparam logic [REPCFG_W-1:0] REPEAT_RESET = 4'd3;
  localparam logic [REPCFG_W-1:0] REPEAT_MAX   = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LINE  = 3'b100
  } seq_state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  pixel_byte;
    logic               pixel_valid;
    logic               audio_toggle;
    logic [FRAME_W-1:0] frame_count;
    logic               last;
  } beat_t;

endpackage
`default_nettype wire

/* sv/srtg_store.sv */
`default_nettype none
module srtg_store
  import srtg_pkg::*;
#(
  parameter int unsigned DEPTH = 1472,
  parameter int unsigned AW    = 11
) (
  input  wire logic              clk_i,
  input  wire mem_ctl_t          ctl_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // read data register only moves on a read, so it doubles as a hold stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/srtg_seq.sv */
`default_nettype none
`include "scanline_repeat_tone_generator_macros.svh"
module srtg_seq
  import srtg_pkg::*;
#(
  parameter int unsigned ROWS      = 64,
  parameter int unsigned ROW_BYTES = 23,
  parameter int unsigned AW        = 11
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CMD_W-1:0]     in_cmd_i,
  input  wire logic [ADDR_W-1:0]    in_addr_i,
  input  wire logic [BYTE_W-1:0]    in_data_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i,
  output mem_ctl_t                  mem_ctl_o,
  output logic      [AW-1:0]        mem_waddr_o,
  output logic      [BYTE_W-1:0]    mem_wdata_o,
  output logic      [AW-1:0]        mem_raddr_o,
  input  wire logic [BYTE_W-1:0]    mem_rdata_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output beat_t                     out_beat_o
);

  localparam int unsigned STORE_SIZE = ROWS * ROW_BYTES;
  localparam int unsigned BW         = $clog2(STORE_SIZE + 1);
  localparam int unsigned COL_W      = $clog2(ROW_BYTES + 1);

  seq_state_e state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [BYTE_W-1:0]   tone_period_q, tone_period_d;
  logic [BYTE_W-1:0]   skip_lines_q, skip_lines_d;
  logic [REPCFG_W-1:0] repeat_lines_q, repeat_lines_d;
  logic [BYTE_W-1:0]   tone_count_q, tone_count_d;
  logic [BYTE_W-1:0]   skip_count_q, skip_count_d;
  logic [REP_W-1:0]    repeat_count_q, repeat_count_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [BW-1:0]       row_base_q, row_base_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic                head_q, head_d;
  beat_t               head_beat_q, head_beat_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [BW-1:0]       rd_addr_q, rd_addr_d;
  logic                pend_q, pend_d;
  logic                pend_last_q, pend_last_d;
  logic                out_valid_q, out_valid_d;
  beat_t               out_beat_q, out_beat_d;

  logic                in_fire;
  logic                advance;
  logic                col_full;
  logic                take_head;
  logic                take_data;
  logic                line_done;
  logic                toggle;
  logic                display;
  logic [REPCFG_W-1:0] rep_eff;
  mem_ctl_t            mem_ctl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign advance    = !out_valid_q || out_ready_i;
  assign col_full   = (col_q == COL_W'(ROW_BYTES));
  assign take_head  = (state_q == ST_LINE) && advance && head_q;
  assign take_data  = (state_q == ST_LINE) && advance && !head_q && pend_q;
  assign line_done  = (state_q == ST_LINE) && col_full &&
                      ((head_q && !pend_q && take_head) || (!head_q && !pend_q) || take_data);

  // prefetch one byte ahead; the read register holds it while the output stalls
  assign mem_ctl.rd_en = (state_q == ST_LINE) && !col_full &&
                         (!pend_q || (advance && !head_q));
  assign mem_ctl.wr_en = (state_q == ST_CLEAR) ||
                         (in_fire && (in_cmd_i == CMD_STORE) &&
                          (32'(in_addr_i) < STORE_SIZE));
  assign mem_waddr_o   = (state_q == ST_CLEAR) ? clr_q : AW'(in_addr_i);
  assign mem_wdata_o   = (state_q == ST_CLEAR) ? '0 : in_data_i;
  assign mem_raddr_o   = AW'(rd_addr_q);
  assign mem_ctl_o     = mem_ctl;

  assign toggle  = (tone_period_q != '0) && (tone_count_q == '0);
  assign display = (skip_count_q == '0) && (row_q < ROW_W'(ROWS));

  always_comb begin
    priority if (repeat_lines_q == '0) begin
      rep_eff = REPCFG_W'(1);
    end else if (repeat_lines_q > REPEAT_MAX) begin
      rep_eff = REPEAT_MAX;
    end else begin
      rep_eff = repeat_lines_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    tone_period_d  = tone_period_q;
    skip_lines_d   = skip_lines_q;
    repeat_lines_d = repeat_lines_q;
    tone_count_d   = tone_count_q;
    skip_count_d   = skip_count_q;
    repeat_count_d = repeat_count_q;
    row_d          = row_q;
    row_base_d     = row_base_q;
    frame_d        = frame_q;
    head_d         = head_q;
    head_beat_d    = head_beat_q;
    col_d          = col_q;
    rd_addr_d      = rd_addr_q;
    pend_d         = pend_q;
    pend_last_d    = pend_last_q;
    out_valid_d    = out_valid_q;
    out_beat_d     = out_beat_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TONE: begin
          tone_period_d = cfg_data_i;
          if (cfg_data_i != '0) begin
            tone_count_d = cfg_data_i;
          end
        end
        REG_SKIP:   skip_lines_d   = cfg_data_i;
        REG_REPEAT: repeat_lines_d = cfg_data_i[REPCFG_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(STORE_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd_i)
            CMD_HSYNC: begin
              if (tone_period_q != '0) begin
                tone_count_d = toggle ? tone_period_q : tone_count_q - 8'd1;
              end
              if (skip_count_q != '0) begin
                skip_count_d = skip_count_q - 8'd1;
              end else if (display) begin
                if ({1'b0, repeat_count_q} + REPCFG_W'(1) >= rep_eff) begin
                  repeat_count_d = '0;
                  row_d          = row_q + ROW_W'(1);
                  row_base_d     = row_base_q + BW'(ROW_BYTES);
                end else begin
                  repeat_count_d = repeat_count_q + REP_W'(1);
                end
              end
              head_d                   = 1'b1;
              head_beat_d.pixel_byte   = '0;
              head_beat_d.pixel_valid  = display;
              head_beat_d.audio_toggle = toggle;
              head_beat_d.frame_count  = frame_q;
              head_beat_d.last         = !display;
              col_d                    = display ? '0 : COL_W'(ROW_BYTES);
              rd_addr_d                = row_base_q;
              state_d                  = ST_LINE;
            end
            CMD_VSYNC: begin
              skip_count_d   = skip_lines_q;
              row_d          = '0;
              row_base_d     = '0;
              repeat_count_d = '0;
              frame_d        = frame_q + FRAME_W'(1);
            end
            default: ;
          endcase
        end
      end
      ST_LINE: begin
        if (line_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (take_head) begin
      head_d = 1'b0;
    end

    if (mem_ctl.rd_en) begin
      pend_d      = 1'b1;
      pend_last_d = (col_q == COL_W'(ROW_BYTES - 1));
      col_d       = col_q + COL_W'(1);
      rd_addr_d   = rd_addr_q + BW'(1);
    end else if (take_data) begin
      pend_d = 1'b0;
    end

    if (advance) begin
      out_valid_d = take_head || take_data;
      if (take_head) begin
        out_beat_d = head_beat_q;
      end else begin
        out_beat_d.pixel_byte   = mem_rdata_i;
        out_beat_d.pixel_valid  = 1'b1;
        out_beat_d.audio_toggle = 1'b0;
        out_beat_d.frame_count  = frame_q;
        out_beat_d.last         = pend_last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      tone_period_q  <= '0;
      skip_lines_q   <= SKIP_RESET;
      repeat_lines_q <= REPEAT_RESET;
      tone_count_q   <= '0;
      skip_count_q   <= '0;
      repeat_count_q <= '0;
      row_q          <= '0;
      row_base_q     <= '0;
      frame_q        <= '0;
      head_q         <= 1'b0;
      col_q          <= '0;
      rd_addr_q      <= '0;
      pend_q         <= 1'b0;
      pend_last_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      tone_period_q  <= tone_period_d;
      skip_lines_q   <= skip_lines_d;
      repeat_lines_q <= repeat_lines_d;
      tone_count_q   <= tone_count_d;
      skip_count_q   <= skip_count_d;
      repeat_count_q <= repeat_count_d;
      row_q          <= row_d;
      row_base_q     <= row_base_d;
      frame_q        <= frame_d;
      head_q         <= head_d;
      col_q          <= col_d;
      rd_addr_q      <= rd_addr_d;
      pend_q         <= pend_d;
      pend_last_q    <= pend_last_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_beat_q <= head_beat_d;
    out_beat_q  <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `SRTG_ASSERT(a_no_rw_clash, clk_i, rst_ni, mem_ctl.rd_en, !mem_ctl.wr_en)
  `SRTG_ASSERT(a_rd_in_line, clk_i, rst_ni, mem_ctl.rd_en, (state_q == ST_LINE) && !col_full)
  `SRTG_ASSERT(a_pend_kept, clk_i, rst_ni, pend_q && !take_data, !mem_ctl.rd_en)
  `SRTG_ASSERT_NEXT(a_hsync_line, clk_i, rst_ni, in_fire && (in_cmd_i == CMD_HSYNC), (state_q == ST_LINE) && head_q)

endmodule
`default_nettype wire

/* sv/scanline_repeat_tone_generator.sv */
// scan-out sequencer for a low-resolution, line-repeated vga frame
//
// input stream (s_axis_*): one beat per command. tuser carries the command
// (hsync tick, vsync frame start, frame store write), tdata the store
// address and byte. vsync and store writes give no beat.
// an hsync tick gives one beat on a blank line (skip lines, or rows past the
// end) or a black byte plus ROW_BYTES row bytes on a displayed line.
// output stream (m_axis_*): tlast marks the final beat of a tick.
// a displayed line streams one byte per cycle from the frame store while
// m_axis_tready is high; the single read port and its read register set
// the pace.
// one command is in flight at a time; s_axis_tready is high only while idle.
// when m_axis_tready is low the output register holds its beat and the
// store's read register holds the next byte; nothing is dropped.
// after reset the frame store is swept to zero, one byte a cycle, over
// all ROWS * ROW_BYTES bytes; s_axis_tready stays low meanwhile, while the
// configuration channel is always ready.
`default_nettype none
module scanline_repeat_tone_generator
  import srtg_pkg::*;
#(
  parameter int unsigned ROWS      = 64,
  parameter int unsigned ROW_BYTES = 23
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [23:0]          s_axis_tdata,   // store_addr[10:0], store_data[18:11]
  input  wire logic [CMD_W-1:0]     s_axis_tuser,   // cmd[1:0]
  // output stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [31:0]          m_axis_tdata,   // pixel_byte[7:0], audio_toggle[8],
                                                    // frame_count[24:9]
  output logic                      m_axis_tuser,   // pixel_valid
  output logic                      m_axis_tlast,
  // register writes: 0 tone period, 1 skip lines, 2 repeat lines
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i
);

  localparam int unsigned STORE_SIZE = ROWS * ROW_BYTES;
  localparam int unsigned AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  beat_t             beat;

  // registers take a write every cycle
  assign cfg_ready_o = 1'b1;

  srtg_seq #(
    .ROWS      (ROWS),
    .ROW_BYTES (ROW_BYTES),
    .AW        (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[ADDR_W-1:0]),
    .in_data_i   (s_axis_tdata[ADDR_W+BYTE_W-1:ADDR_W]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (beat)
  );

  // frame store: one write port for clear sweep and store writes, one read port
  srtg_store #(
    .DEPTH (STORE_SIZE),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // pack the result beat, first field lowest, zero fill to 32 bits
  assign m_axis_tdata = {7'b0, beat.frame_count, beat.audio_toggle, beat.pixel_byte};
  assign m_axis_tuser = beat.pixel_valid;
  assign m_axis_tlast = beat.last;

endmodule
`default_nettype wire
